@@ hdl/spc_pkg.sv @@
// Shared types, constants and mode codes of the per-slot error counter block.
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

    // Number of meter slots kept in the counter memory (1 to 16).
    localparam int SLOTS   = 8;
    localparam int SLOT_W  = 4;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MODE_W  = 3;
    localparam int CNT_W   = 32;
    localparam int PCT_W   = 7;
    // Wide enough for (crc + timeouts) * 100 on the division path.
    localparam int NUM_W   = CNT_W + 1 + PCT_W;
    localparam int STEP_W  = $clog2(PCT_W);

    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [PCT_W-1:0] PERCENT_FULL = PCT_W'(100);

    typedef enum logic [MODE_W-1:0] {
        MODE_INC_REQ   = 3'd0,
        MODE_INC_RSP   = 3'd1,
        MODE_INC_CRC   = 3'd2,
        MODE_INC_TMO   = 3'd3,
        MODE_CLR_SLOT  = 3'd4,
        MODE_CLR_ALL   = 3'd5,
        MODE_READ      = 3'd6,
        MODE_RATE      = 3'd7
    } t_mode;

    // One memory row: the four counters of a slot.
    typedef struct packed {
        logic [CNT_W-1:0] requests;
        logic [CNT_W-1:0] responses;
        logic [CNT_W-1:0] crc_errors;
        logic [CNT_W-1:0] timeouts;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [CNT_W:0]   errs;
        logic [CNT_W-1:0] reqs;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] percent;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ hdl/spc_pct_div.sv @@
// Error-rate unit: scales the error count by 100 and divides by requests, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module spc_pct_div
    import spc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [PCT_W-1:0] r_quo;

    logic             n_fits;
    logic             n_early;

    assign n_fits  = (r_rem >= r_dsh);
    // No requests, or errors at or above the request count, need no division.
    assign n_early = (i_req.reqs == '0) || (i_req.errs >= {1'b0, i_req.reqs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start ? n_early : (r_busy && (r_step == '0));
            if (i_req.start) begin
                r_busy <= !n_early;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Restoring division: the quotient is below 128, so seven compare and
    // subtract steps with the divisor shifted down from bit six suffice.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_step <= STEP_W'(PCT_W - 1);
            r_rem  <= NUM_W'(i_req.errs) * NUM_W'(PERCENT_FULL);
            r_dsh  <= NUM_W'(i_req.reqs) << (PCT_W - 1);
            if (i_req.reqs == '0) begin
                r_quo <= '0;
            end else if (i_req.errs >= {1'b0, i_req.reqs}) begin
                r_quo <= PERCENT_FULL;
            end else begin
                r_quo <= '0;
            end
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            r_dsh  <= r_dsh >> 1;
            r_quo  <= {r_quo[PCT_W-2:0], n_fits};
            if (n_fits) begin
                r_rem <= r_rem - r_dsh;
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.percent = r_quo;

endmodule

`default_nettype wire

@@ hdl/per_slot_error_counters_unit.sv @@
// Top level of the per-slot error counter block: counter memory, sequencer and result register.
// A request on the input channel (i_in_valid, i_mode, i_slot) increments one
// of the four saturating counters of a slot, clears a slot, clears every
// slot, reads a slot, or reads it with its error rate. The request is taken
// at a rising edge where i_in_valid is high and o_in_stall is low. Every
// request yields exactly one result on the output channel (o_out_valid and
// the result fields), taken at an edge where o_out_valid is high and
// i_out_stall is low.
// A clear all or an out-of-range request goes straight to the result
// register; all other modes pass the read of the counter memory, the
// read-modify-write step and the seven-step error-rate divider, which ends
// early when the slot has no requests or its errors reach the request count.
// One request is in flight at a time, so a new request is taken only once
// the last one has reached the result register.
// Reset clears the per-slot valid bits, so every counter reads as zero; no
// clearing pass is needed. Clear all acts the same way.
// While the receiver stalls, the result register holds its value; the next
// request is still taken and worked on, and waits before the result
// register until the stalled result has been taken.
`timescale 1ns / 1ps
`default_nettype none

module per_slot_error_counters_unit
    import spc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [SLOT_W-1:0] i_slot,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_slot_ok,
    output logic [CNT_W-1:0]       o_requests,
    output logic [CNT_W-1:0]       o_responses,
    output logic [CNT_W-1:0]       o_crc_errors,
    output logic [CNT_W-1:0]       o_timeouts,
    output logic [PCT_W-1:0]       o_error_percent
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] val);
        logic [CNT_W-1:0] res;
        res = (val == CNT_MAX) ? val : val + CNT_W'(1);
        return res;
    endfunction

    t_state r_state;
    t_mode  r_mode;
    logic [SLOT_AW-1:0] r_addr;

    // Counter memory with a valid bit per row; an invalid row reads as zero.
    t_entry r_mem [SLOTS];
    logic   r_vld [SLOTS];
    t_entry r_rd_data;
    logic   r_rd_vld;

    // Result being assembled, then the output register.
    logic             r_ok;
    t_entry           r_cnt;
    logic [PCT_W-1:0] r_pct;
    logic             r_out_valid;
    logic             r_out_ok;
    t_entry           r_out_cnt;
    logic [PCT_W-1:0] r_out_pct;

    logic     n_accept;
    logic     n_in_range;
    logic     n_out_free;
    t_entry   n_cur;
    t_entry   n_cnt;
    t_div_req n_div_req;
    t_div_rsp n_div_rsp;

    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_in_range = ({1'b0, i_slot} < (SLOT_W + 1)'(SLOTS));
    assign n_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Modify step: the row read last cycle, with the mode applied.
    always_comb begin
        n_cur = r_rd_vld ? r_rd_data : '0;
        n_cnt = n_cur;
        case (r_mode)
            MODE_INC_REQ:  n_cnt.requests   = sat_inc(n_cur.requests);
            MODE_INC_RSP:  n_cnt.responses  = sat_inc(n_cur.responses);
            MODE_INC_CRC:  n_cnt.crc_errors = sat_inc(n_cur.crc_errors);
            MODE_INC_TMO:  n_cnt.timeouts   = sat_inc(n_cur.timeouts);
            MODE_CLR_SLOT: n_cnt            = '0;
            default:       n_cnt            = n_cur;
        endcase
    end

    assign n_div_req.start = (r_state == S_MOD);
    assign n_div_req.errs  = {1'b0, n_cnt.crc_errors} + {1'b0, n_cnt.timeouts};
    assign n_div_req.reqs  = n_cnt.requests;

    spc_pct_div u_pct_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    // Memory port: read at request time, written back in the modify step.
    // Only one request is in flight, so a read never meets a pending write.
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_rd_data <= r_mem[i_slot[SLOT_AW-1:0]];
        end
        if (r_state == S_MOD) begin
            r_mem[r_addr] <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (n_accept) begin
                r_rd_vld <= r_vld[i_slot[SLOT_AW-1:0]];
            end
            if (n_accept && (t_mode'(i_mode) == MODE_CLR_ALL)) begin
                for (int k = 0; k < SLOTS; k++) begin
                    r_vld[k] <= 1'b0;
                end
            end else if (r_state == S_MOD) begin
                r_vld[r_addr] <= 1'b1;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if ((t_mode'(i_mode) == MODE_CLR_ALL) || !n_in_range) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result assembly; clear all and a rejected slot give all-zero fields.
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_mode <= t_mode'(i_mode);
            r_addr <= i_slot[SLOT_AW-1:0];
            r_ok   <= n_in_range || (t_mode'(i_mode) == MODE_CLR_ALL);
            r_cnt  <= '0;
            r_pct  <= '0;
        end else if (r_state == S_MOD) begin
            r_cnt <= n_cnt;
        end else if ((r_state == S_DIV) && n_div_rsp.done) begin
            r_pct <= n_div_rsp.percent;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && n_out_free) begin
            r_out_ok  <= r_ok;
            r_out_cnt <= r_cnt;
            r_out_pct <= r_pct;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_slot_ok       = r_out_ok;
    assign o_requests      = r_out_cnt.requests;
    assign o_responses     = r_out_cnt.responses;
    assign o_crc_errors    = r_out_cnt.crc_errors;
    assign o_timeouts      = r_out_cnt.timeouts;
    assign o_error_percent = r_out_pct;

    // The error rate never exceeds one hundred percent.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_percent <= PERCENT_FULL))
        else $error("error rate above one hundred percent");

    // A rejected slot reports zero request and timeout counters and a zero rate.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_slot_ok) |->
            ((o_requests == '0) && (o_timeouts == '0) && (o_error_percent == '0)))
        else $error("rejected slot reports nonzero fields");

    // A slot with no requests has a zero rate.
    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_requests == '0)) |-> (o_error_percent == '0))
        else $error("nonzero rate for a slot without requests");

    // An increment never makes the request counter smaller.
    a_sat_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOD) && (r_mode == MODE_INC_REQ)) |->
            (n_cnt.requests >= n_cur.requests))
        else $error("request counter wrapped");

endmodule

`default_nettype wire
